@@ rtl/rsnh_pkg.sv @@
`default_nettype none
package rsnh_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // direction x: n = 8192*x + W, q = floor(n / 2W) - KX
  localparam longint KX     = 2048;
  localparam longint DX     = 2 * SCREEN_WIDTH;
  localparam longint NX_MAX = 8192 * 1023 + SCREEN_WIDTH;
  localparam int     NXW    = $clog2(NX_MAX + 1);
  localparam longint MX     = (longint'(1) << NXW) / DX;
  localparam int     MXW    = $clog2(MX + 1);
  localparam int     QXW    = $clog2(NX_MAX / DX + 2);

  // direction y: n = CY - 8192*y, q = floor(n / 2H) - KY
  localparam longint KY     = (4096 * 511 + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;
  localparam longint DY     = 2 * SCREEN_HEIGHT;
  localparam longint CY     = SCREEN_HEIGHT * 4097 + KY * DY;
  localparam longint NY_MAX = CY;
  localparam int     NYW    = $clog2(NY_MAX + 1);
  localparam longint MY     = (longint'(1) << NYW) / DY;
  localparam int     MYW    = $clog2(MY + 1);
  localparam int     QYW    = $clog2(NY_MAX / DY + 2);

  // direction components, 12 fraction bits, clamped to +-2.0
  localparam int DIR_W   = 15;
  localparam int DIR_MAX = 8192;

  // pipeline depth
  localparam int DIR_LAT    = 4;
  localparam int ROOT_STEPS = 32;
  localparam int SPH_LAT    = ROOT_STEPS + 5;
  localparam int PIPE_LAT   = DIR_LAT + SPH_LAT;

  localparam int NUM_W = 34;

  // register reset values
  localparam logic [47:0] CAMERA_RST   = 48'd0;
  localparam logic [63:0] SPHERE_A_RST = 64'd72060896851001344;
  localparam logic [63:0] SPHERE_B_RST = 64'd72061992084439552;
  localparam logic [63:0] SPHERE_C_RST = 64'd72061992084504064;

  typedef enum logic [1:0] {
    REG_CAMERA   = 2'd0,
    REG_SPHERE_A = 2'd1,
    REG_SPHERE_B = 2'd2,
    REG_SPHERE_C = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_A    = 2'd1,
    HIT_B    = 2'd2,
    HIT_C    = 2'd3
  } hit_e;

  // one step of the square root chain
  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        root;
    logic               miss;
    logic signed [31:0] h;
  } root_t;

  // colour as {red, green, blue}
  function automatic logic [23:0] colour(input hit_e hit);
    logic [23:0] c;
    unique case (hit)
      HIT_A:   c = {8'd127, 8'd0, 8'd0};
      HIT_B:   c = {8'd0, 8'd0, 8'd127};
      HIT_C:   c = {8'd0, 8'd127, 8'd0};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ray_sphere_nearest_hit.sv @@
// Ray against three spheres, nearest hit. One pixel request per clock is accepted
// (in_valid_i high, in_stall_o low) and its colour comes out of an output register,
// one result per request in request order. The depth is set by the direction
// divider (4 stages), the sphere arithmetic (5 stages) and a 32-cell square root
// chain. A stalled output holds its result and the block keeps accepting until a
// second finished result is parked; then in_stall_o rises and the pipeline holds.
// Configuration (camera, three spheres) is to be written through the cfg port only
// while no requests are in flight, not enforced here; cfg_ready_o is always high.
`default_nettype none
module ray_sphere_nearest_hit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  object_hit_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import rsnh_pkg::*;

  logic [47:0] camera_q;
  logic [63:0] sphere_a_q, sphere_b_q, sphere_c_q;

  logic        en, in_acc, push, free;
  logic [PIPE_LAT-1:0] vld_q;

  logic signed [DIR_W-1:0] dx, dy;
  logic        hit_a, hit_b, hit_c;
  logic signed [NUM_W-1:0] num_a, num_b, num_c, best;
  hit_e        hit;

  logic        ov_q, skid_full_q;
  hit_e        obj_q, skid_obj_q;
  logic [23:0] col_q, skid_col_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_q   <= CAMERA_RST;
      sphere_a_q <= SPHERE_A_RST;
      sphere_b_q <= SPHERE_B_RST;
      sphere_c_q <= SPHERE_C_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_CAMERA:   camera_q   <= cfg_data_i[47:0];
        REG_SPHERE_A: sphere_a_q <= cfg_data_i;
        REG_SPHERE_B: sphere_b_q <= cfg_data_i;
        REG_SPHERE_C: sphere_c_q <= cfg_data_i;
      endcase
    end
  end

  // pipeline advances unless the skid stage is occupied
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push       = en && vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_acc};
    end
  end

  rsnh_dir u_dir (
    .clk_i     (clk_i),
    .en_i      (en),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .dx_o      (dx),
    .dy_o      (dy)
  );

  rsnh_sphere u_sph_a (
    .clk_i (clk_i), .en_i (en), .dx_i (dx), .dy_i (dy),
    .cam_i (camera_q), .sph_i (sphere_a_q), .hit_o (hit_a), .num_o (num_a)
  );

  rsnh_sphere u_sph_b (
    .clk_i (clk_i), .en_i (en), .dx_i (dx), .dy_i (dy),
    .cam_i (camera_q), .sph_i (sphere_b_q), .hit_o (hit_b), .num_o (num_b)
  );

  rsnh_sphere u_sph_c (
    .clk_i (clk_i), .en_i (en), .dx_i (dx), .dy_i (dy),
    .cam_i (camera_q), .sph_i (sphere_c_q), .hit_o (hit_c), .num_o (num_c)
  );

  // nearest hit, earlier sphere wins a tie
  always_comb begin
    hit  = HIT_NONE;
    best = num_a;
    if (hit_a) begin
      hit  = HIT_A;
      best = num_a;
    end
    if (hit_b && (hit == HIT_NONE || num_b < best)) begin
      hit  = HIT_B;
      best = num_b;
    end
    if (hit_c && (hit == HIT_NONE || num_c < best)) begin
      hit  = HIT_C;
      best = num_c;
    end
  end

  // output register with one skid entry
  assign free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q        <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (free) begin
      if (skid_full_q) begin
        ov_q        <= 1'b1;
        skid_full_q <= 1'b0;
      end else begin
        ov_q <= push;
      end
    end else if (push) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (skid_full_q) begin
        obj_q <= skid_obj_q;
        col_q <= skid_col_q;
      end else if (push) begin
        obj_q <= hit;
        col_q <= colour(hit);
      end
    end else if (push) begin
      skid_obj_q <= hit;
      skid_col_q <= colour(hit);
    end
  end

  assign out_valid_o  = ov_q;
  assign object_hit_o = obj_q;
  assign red_o        = col_q[23:16];
  assign green_o      = col_q[15:8];
  assign blue_o       = col_q[7:0];

endmodule
`default_nettype wire

@@ rtl/rsnh_dir.sv @@
`default_nettype none
module rsnh_dir (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [9:0]                        pixel_x_i,
  input  logic [8:0]                        pixel_y_i,
  output logic signed [rsnh_pkg::DIR_W-1:0] dx_o,
  output logic signed [rsnh_pkg::DIR_W-1:0] dy_o
);
  import rsnh_pkg::*;

  logic [NXW-1:0] nx_q, nx2_q, nx3_q;
  logic [NYW-1:0] ny_q, ny2_q, ny3_q;
  logic [QXW-1:0] qx_q, qx3_q;
  logic [QYW-1:0] qy_q, qy3_q;
  logic [NXW-1:0] px_q;
  logic [NYW-1:0] py_q;

  logic [NXW+MXW-1:0] prodx;
  logic [NYW+MYW-1:0] prody;
  logic [NXW-1:0]     remx;
  logic [NYW-1:0]     remy;
  logic [QXW-1:0]     qcx;
  logic [QYW-1:0]     qcy;
  logic signed [31:0] vx, vy;
  logic signed [DIR_W-1:0] dx_d, dy_d;

  // reciprocal multiply, result is the quotient or one below
  assign prodx = (NXW+MXW)'(nx_q) * (NXW+MXW)'(MX);
  assign prody = (NYW+MYW)'(ny_q) * (NYW+MYW)'(MY);

  // one correction step, then remove the bias and clamp
  always_comb begin
    remx = nx3_q - px_q;
    remy = ny3_q - py_q;
    qcx  = (remx >= NXW'(DX)) ? qx3_q + QXW'(1) : qx3_q;
    qcy  = (remy >= NYW'(DY)) ? qy3_q + QYW'(1) : qy3_q;
    vx   = $signed({{(32-QXW){1'b0}}, qcx}) - 32'(KX);
    vy   = $signed({{(32-QYW){1'b0}}, qcy}) - 32'(KY);
    if (vx > 32'sd8192)       dx_d = DIR_W'(DIR_MAX);
    else if (vx < -32'sd8192) dx_d = -DIR_W'(DIR_MAX);
    else                      dx_d = DIR_W'(vx);
    if (vy > 32'sd8192)       dy_d = DIR_W'(DIR_MAX);
    else if (vy < -32'sd8192) dy_d = -DIR_W'(DIR_MAX);
    else                      dy_d = DIR_W'(vy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q  <= NXW'({pixel_x_i, 13'd0}) + NXW'(SCREEN_WIDTH);
      ny_q  <= NYW'(CY) - NYW'({pixel_y_i, 13'd0});
      nx2_q <= nx_q;
      ny2_q <= ny_q;
      qx_q  <= QXW'(prodx >> NXW);
      qy_q  <= QYW'(prody >> NYW);
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      qx3_q <= qx_q;
      qy3_q <= qy_q;
      px_q  <= NXW'(qx_q) * NXW'(DX);
      py_q  <= NYW'(qy_q) * NYW'(DY);
      dx_o  <= dx_d;
      dy_o  <= dy_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rsnh_root_cell.sv @@
`default_nettype none
module rsnh_root_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [4:0]            step_i,
  input  rsnh_pkg::root_t       prev_i,
  output rsnh_pkg::root_t       next_o
);
  import rsnh_pkg::*;

  logic [5:0]  sh;
  logic [63:0] bitv;
  logic [63:0] trial;
  root_t       nxt;

  // one result bit per cell, two radicand bits consumed
  always_comb begin
    sh    = {5'd31 - step_i, 1'b0};
    bitv  = 64'd1 << sh;
    trial = prev_i.root + bitv;
    nxt   = prev_i;
    if (prev_i.rem >= trial) begin
      nxt.rem  = prev_i.rem - trial;
      nxt.root = (prev_i.root >> 1) + bitv;
    end else begin
      nxt.root = prev_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      next_o <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rsnh_sphere.sv @@
`default_nettype none
module rsnh_sphere (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [rsnh_pkg::DIR_W-1:0] dx_i,
  input  logic signed [rsnh_pkg::DIR_W-1:0] dy_i,
  input  logic [47:0]                       cam_i,
  input  logic [63:0]                       sph_i,
  output logic                              hit_o,
  output logic signed [rsnh_pkg::NUM_W-1:0] num_o
);
  import rsnh_pkg::*;

  logic signed [16:0] relx, rely, relz;
  logic signed [15:0] rad;

  logic signed [31:0] px_q, py_q;
  logic signed [28:0] pz_q;
  logic signed [33:0] sqx_q, sqy_q, sqz_q;
  logic signed [31:0] rr_q;
  logic signed [27:0] ax_q, ay_q;
  logic signed [31:0] h_q, h2_q, h3_q;
  logic signed [29:0] a_q;
  logic signed [35:0] c_q;
  logic signed [63:0] hh_q, ac_q, d_d;
  logic [63:0]        d_q;
  logic               miss_q;

  root_t chain [ROOT_STEPS+1];

  // centre relative to the camera
  assign relx = $signed({sph_i[15], sph_i[15:0]})  - $signed({cam_i[15], cam_i[15:0]});
  assign rely = $signed({sph_i[31], sph_i[31:16]}) - $signed({cam_i[31], cam_i[31:16]});
  assign relz = $signed({sph_i[47], sph_i[47:32]}) - $signed({cam_i[47], cam_i[47:32]});
  assign rad  = $signed(sph_i[63:48]);
  assign d_d  = hh_q - ac_q;

  // products, sums, squares, discriminant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= 32'(dx_i) * 32'(relx);
      py_q   <= 32'(dy_i) * 32'(rely);
      pz_q   <= 29'(relz) <<< 12;
      sqx_q  <= 34'(relx) * 34'(relx);
      sqy_q  <= 34'(rely) * 34'(rely);
      sqz_q  <= 34'(relz) * 34'(relz);
      rr_q   <= 32'(rad) * 32'(rad);
      ax_q   <= 28'(dx_i) * 28'(dx_i);
      ay_q   <= 28'(dy_i) * 28'(dy_i);
      h_q    <= px_q + py_q + 32'(pz_q);
      a_q    <= 30'(ax_q) + 30'(ay_q) + 30'sd16777216;
      c_q    <= 36'(sqx_q) + 36'(sqy_q) + 36'(sqz_q) - 36'(rr_q);
      hh_q   <= 64'(h_q) * 64'(h_q);
      ac_q   <= 64'(a_q) * 64'(c_q);
      h2_q   <= h_q;
      d_q    <= d_d;
      miss_q <= d_d[63];
      h3_q   <= h2_q;
    end
  end

  assign chain[0] = '{rem: d_q, root: 64'd0, miss: miss_q, h: h3_q};

  // square root chain
  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    rsnh_root_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .step_i (5'(i)),
      .prev_i (chain[i]),
      .next_o (chain[i+1])
    );
  end

  // numerator of the near root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= !chain[ROOT_STEPS].miss;
      num_o <= NUM_W'(chain[ROOT_STEPS].h)
             - $signed({2'b00, chain[ROOT_STEPS].root[31:0]});
    end
  end

endmodule
`default_nettype wire

@@ rtl/rsnh_checker.sv @@
`default_nettype none
module rsnh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [9:0]  pixel_x_i,
  input wire logic [8:0]  pixel_y_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  object_hit_o,
  input wire logic [7:0]  red_o,
  input wire logic [7:0]  green_o,
  input wire logic [7:0]  blue_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [1:0]  cfg_index_i,
  input wire logic [63:0] cfg_data_i
);
  import rsnh_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(object_hit_o)
      && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

  // colour follows the object code
  a_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (object_hit_o == HIT_NONE && red_o == 8'd255 && green_o == 8'd255 && blue_o == 8'd255)
   || (object_hit_o == HIT_A && red_o == 8'd127 && green_o == 8'd0 && blue_o == 8'd0)
   || (object_hit_o == HIT_B && red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd127)
   || (object_hit_o == HIT_C && red_o == 8'd0 && green_o == 8'd127 && blue_o == 8'd0))
    else $error("colour does not match object");

  // input stalls only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // parked result implies a pending output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind ray_sphere_nearest_hit rsnh_checker u_rsnh_checker (.*);
`default_nettype wire

@@ verif/tb_ray_sphere_nearest_hit.sv @@
`timescale 1ns / 100ps
module tb_ray_sphere_nearest_hit;
  import rsnh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    hit_e       hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [9:0]  pixel_x_i;
  logic [8:0]  pixel_y_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  object_hit_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  ray_sphere_nearest_hit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .pixel_x_i(pixel_x_i), .pixel_y_i(pixel_y_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .object_hit_o(object_hit_o), .red_o(red_o), .green_o(green_o), .blue_o(blue_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // shadow of the scene registers
  logic [47:0] cam_q;
  logic [63:0] sphere_q [3];

  shade_t shade_queue[$];
  int     errors;
  int     pixels_sent;
  int     shades_checked;
  int     hit_count [4];
  int     cfg_writes;
  bit     hold_req;
  bit     no_gaps;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // signed 16-bit slice of a packed register
  function automatic longint field16(logic [63:0] w, int pos);
    logic [15:0] s;
    s = w[pos +: 16];
    return longint'($signed(s));
  endfunction

  // ray direction component, round half up, clamped to +-2.0
  function automatic longint ray_dir(longint twice_off, longint size);
    longint num;
    longint den;
    longint q;
    num = 4096 * twice_off + size;
    den = 2 * size;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    if (q > 8192) q = 8192;
    if (q < -8192) q = -8192;
    return q;
  endfunction

  // floor square root, one bit at a time from the top
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // nearest sphere along the ray through one pixel
  function automatic shade_t shade_pixel(logic [9:0] px, logic [8:0] py);
    longint dir [3];
    longint rel [3];
    longint h, a, c, rad, disc, num, best;
    hit_e   hit;
    shade_t s;
    dir[0] = ray_dir(2 * longint'(px) - SCREEN_WIDTH, SCREEN_WIDTH);
    dir[1] = ray_dir(SCREEN_HEIGHT - 2 * longint'(py), SCREEN_HEIGHT);
    dir[2] = 4096;
    hit  = HIT_NONE;
    best = 0;
    for (int k = 0; k < 3; k++) begin
      h = 0;
      a = 0;
      for (int i = 0; i < 3; i++) begin
        rel[i] = field16(sphere_q[k], 16 * i) - field16({16'd0, cam_q}, 16 * i);
        h += dir[i] * rel[i];
        a += dir[i] * dir[i];
      end
      rad  = field16(sphere_q[k], 48);
      c    = rel[0] * rel[0] + rel[1] * rel[1] + rel[2] * rel[2] - rad * rad;
      disc = h * h - a * c;
      if (disc >= 0) begin
        num = h - longint'(floor_sqrt(disc));
        if (hit == HIT_NONE || num < best) begin
          best = num;
          hit  = hit_e'(k + 1);
        end
      end
    end
    s.hit = hit;
    case (hit)
      HIT_A:   {s.red, s.green, s.blue} = {8'd127, 8'd0, 8'd0};
      HIT_B:   {s.red, s.green, s.blue} = {8'd0, 8'd0, 8'd127};
      HIT_C:   {s.red, s.green, s.blue} = {8'd0, 8'd127, 8'd0};
      default: {s.red, s.green, s.blue} = {8'd255, 8'd255, 8'd255};
    endcase
    return s;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one pixel request; valid stays high until the next gap
  task automatic send_pixel(logic [9:0] px, logic [8:0] py);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    do @(posedge clk_i); while (in_stall_o);
    shade_queue.push_back(shade_pixel(px, py));
    pixels_sent++;
  endtask

  task automatic stop_pixels();
    in_valid_i <= 1'b0;
  endtask

  // wait for every result, then let the pipeline go quiet
  task automatic drain();
    stop_pixels();
    while (shade_queue.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  // register write; valid is left high so writes can go back to back
  task automatic write_reg(reg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CAMERA:   cam_q = data[47:0];
      REG_SPHERE_A: sphere_q[0] = data;
      REG_SPHERE_B: sphere_q[1] = data;
      default:      sphere_q[2] = data;
    endcase
    cfg_writes++;
  endtask

  task automatic set_scene(logic [63:0] cam, logic [63:0] sa, logic [63:0] sb,
                           logic [63:0] sc);
    drain();
    write_reg(REG_CAMERA, cam);
    write_reg(REG_SPHERE_A, sa);
    write_reg(REG_SPHERE_B, sb);
    write_reg(REG_SPHERE_C, sc);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] pack_sphere(int x, int y, int z, int r);
    return {16'(r), 16'(z), 16'(y), 16'(x)};
  endfunction

  // a sphere somewhere in front of the camera, radius 0.25 .. 4
  function automatic logic [63:0] near_sphere();
    return pack_sphere($urandom_range(0, 2048) - 1024, $urandom_range(0, 1536) - 768,
                       $urandom_range(256, 3072), $urandom_range(64, 1024));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic rand_pixel();
    if ($urandom_range(0, 9) == 0) send_pixel(10'($urandom()), 9'($urandom()));
    else send_pixel(10'($urandom_range(0, 639)), 9'($urandom_range(0, 479)));
  endtask

  // corners, centre, off-screen extremes and pixels on the reset spheres, then tie scenes
  task automatic test_directed();
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd0, 9'd479);
    send_pixel(10'd639, 9'd0);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd1023, 9'd0);
    send_pixel(10'd0, 9'd511);
    send_pixel(10'd320, 9'd320);
    send_pixel(10'd480, 9'd240);
    send_pixel(10'd160, 9'd240);
    send_pixel(10'd320, 9'd300);
    // tie: sphere b duplicates a, a must win; c has a negative radius
    set_scene(64'd0, pack_sphere(0, 0, 768, 256), pack_sphere(0, 0, 768, 256),
              pack_sphere(0, 0, 512, -128));
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd330, 9'd250);
    send_pixel(10'd400, 9'd240);
    set_scene(64'd0, pack_sphere(0, 0, 1024, 256), pack_sphere(0, 0, 1024, 256),
              pack_sphere(0, 0, 1024, 256));
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd0, 9'd0);
    stop_pixels();
  endtask

  // register extremes
  task automatic test_config_extremes();
    logic [63:0] vals [4];
    vals[0] = '0;
    vals[1] = '1;
    vals[2] = {4{16'h8000}};
    vals[3] = {4{16'h7fff}};
    for (int i = 0; i < 4; i++) begin
      set_scene(vals[i], vals[i], vals[(i + 1) % 4], vals[(i + 2) % 4]);
      repeat (12) rand_pixel();
    end
    stop_pixels();
  endtask

  // long receiver hold while pixels keep coming, then a full drain, a second run and a drain
  task automatic test_backpressure();
    set_scene(64'd0, near_sphere(), near_sphere(), near_sphere());
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (120) rand_pixel();
    no_gaps = 1'b0;
    drain();
    repeat (30) rand_pixel();
    drain();
  endtask

  // random scenes, mostly plausible, some raw register noise
  task automatic test_random();
    logic [63:0] cam;
    for (int ph = 0; ph < 14; ph++) begin
      cam = (ph % 4 == 3) ? rand64()
            : 64'({16'($urandom_range(0, 512) - 256), 16'($urandom_range(0, 512) - 256),
                   16'($urandom_range(0, 512) - 256)});
      if (ph % 5 == 4) set_scene(cam, rand64(), rand64(), rand64());
      else set_scene(cam, near_sphere(), near_sphere(), near_sphere());
      no_gaps = (ph % 6 == 2);
      repeat (103) rand_pixel();
      no_gaps = 1'b0;
    end
    stop_pixels();
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    shade_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shade_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%0d rgb=%0d,%0d,%0d", $time, object_hit_o,
                 red_o, green_o, blue_o);
        errors++;
      end else begin
        e = shade_queue.pop_front();
        shades_checked++;
        hit_count[e.hit]++;
        if (object_hit_o !== e.hit) begin
          $display("%0t: object_hit expected %0d actual %0d", $time, e.hit, object_hit_o);
          errors++;
        end
        if (red_o !== e.red) begin
          $display("%0t: red expected %0d actual %0d", $time, e.red, red_o);
          errors++;
        end
        if (green_o !== e.green) begin
          $display("%0t: green expected %0d actual %0d", $time, e.green, green_o);
          errors++;
        end
        if (blue_o !== e.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, e.blue, blue_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, shade_queue.size());
        $display("tb_ray_sphere_nearest_hit failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    pixels_sent = 0;
    shades_checked = 0;
    cfg_writes = 0;
    hit_count = '{0, 0, 0, 0};
    hold_req = 1'b0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_x_i = '0;
    pixel_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CAMERA;
    cfg_data_i = '0;
    cam_q = CAMERA_RST;
    sphere_q[0] = SPHERE_A_RST;
    sphere_q[1] = SPHERE_B_RST;
    sphere_q[2] = SPHERE_C_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    drain();

    $display("covered %0d pixels over %0d register writes, incl. a long output hold",
             pixels_sent, cfg_writes);
    $display("nearest: none %0d, a %0d, b %0d, c %0d", hit_count[0], hit_count[1],
             hit_count[2], hit_count[3]);
    if (errors == 0 && shade_queue.size() == 0) begin
      $display("tb_ray_sphere_nearest_hit passed");
    end else begin
      $display("tb_ray_sphere_nearest_hit failed");
    end
    $finish;
  end

endmodule

@@ ray_sphere_nearest_hit.f @@
rtl/rsnh_pkg.sv
rtl/rsnh_dir.sv
rtl/rsnh_root_cell.sv
rtl/rsnh_sphere.sv
rtl/ray_sphere_nearest_hit.sv
rtl/rsnh_checker.sv
verif/tb_ray_sphere_nearest_hit.sv
